/* hdl/mono_bitmap_blitter_top_assert.svh */
// Assertion macros used by the blitter back end.
// Each macro expects clk and rst_n in scope.
`ifndef MONO_BITMAP_BLITTER_TOP_ASSERT_SVH
`define MONO_BITMAP_BLITTER_TOP_ASSERT_SVH

// same-cycle implication
`define MBB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mbb_pkg.sv */
// Package of the mono bitmap blitter: sizes, register codes, channel structs, palette.
// No dependencies.
`timescale 1ns / 1ps

package mbb_pkg;

    localparam int FRAME_WIDTH   = 640;
    localparam int FRAME_HEIGHT  = 480;
    localparam int BITS_PER_WORD = 16;
    localparam int Y_ORIGIN      = 400;

    localparam int ADDR_W     = 19;
    localparam int RGB_W      = 24;
    localparam int POS_W      = 9;
    localparam int DIM_W      = 8;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int BIT_IDX_W = $clog2(BITS_PER_WORD);
    // signed screen coordinate, wide enough for 4*(255+255) and 400+2*511
    localparam int COORD_W   = 13;
    localparam int XW        = $clog2(FRAME_WIDTH);
    localparam int YW        = $clog2(FRAME_HEIGHT);
    localparam int PROD_W    = (XW + YW > ADDR_W) ? XW + YW : ADDR_W;

    // queue depths, powers of two
    localparam int IQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X       = 3'd0,
        REG_START_Y       = 3'd1,
        REG_BITMAP_WIDTH  = 3'd2,
        REG_BITMAP_HEIGHT = 3'd3,
        REG_COLOR_INDEX   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [POS_W-1:0]   start_x;
        logic [POS_W-1:0]   start_y;
        logic [DIM_W-1:0]   bitmap_width;
        logic [DIM_W-1:0]   bitmap_height;
        logic [COLOR_W-1:0] color_index;
    } cfg_t;

    typedef struct packed {
        logic [BITS_PER_WORD-1:0] image_word;
        logic                     first_word;
    } word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [RGB_W-1:0]  color_rgb;
        logic              last;
    } result_t;

    // 16-entry EGA palette
    function automatic logic [RGB_W-1:0] ega_rgb(input logic [COLOR_W-1:0] idx);
        logic [RGB_W-1:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0000AA;
            4'd2:    rgb = 24'h00AA00;
            4'd3:    rgb = 24'h00AAAA;
            4'd4:    rgb = 24'hAA0000;
            4'd5:    rgb = 24'hAA00AA;
            4'd6:    rgb = 24'hAA5500;
            4'd7:    rgb = 24'hAAAAAA;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'h5555FF;
            4'd10:   rgb = 24'h55FF55;
            4'd11:   rgb = 24'h55FFFF;
            4'd12:   rgb = 24'hFF5555;
            4'd13:   rgb = 24'hFF55FF;
            4'd14:   rgb = 24'hFFFF55;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

/* hdl/mono_bitmap_blitter_top.sv */
// Top level of the mono bitmap blitter: front end, back end and result queue.
// Depends on mbb_pkg, mbb_front, mbb_back, mbb_result_fifo.
//
// Channel   Handshake              Accepted when        Payload
// config    cfg_write              cfg_write            cfg_index, cfg_data
// words in  push / full            push && !full        image_word, first_word
// results   empty / pop            pop && !empty        pixel_address, color_rgb, last
//
// Walker: one bitmap bit per cycle while the result queue is not full; a word that
//   meets a finished blit, or ends it part way, leaves the walker at that bit.
// A write passes the address stage and the held-write register to the result queue;
//   each write is held until the next drawn bit or the word's end is seen, so last is
//   exact, and a write followed only by clear or clipped bits waits for the word end.
// Stalls: a full result queue freezes the whole back end; the 2-deep word queue keeps
//   taking requests meanwhile until it is full.
// Reset (rst_n, async low) clears the control registers and marks the blit finished.
`timescale 1ns / 1ps

module mono_bitmap_blitter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mbb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mbb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [mbb_pkg::BITS_PER_WORD-1:0]    image_word,
    input  logic                                first_word,
    output logic                                empty,
    input  logic                                pop,
    output logic [mbb_pkg::ADDR_W-1:0]           pixel_address,
    output logic [mbb_pkg::RGB_W-1:0]            color_rgb,
    output logic                                last
);
    import mbb_pkg::*;

    cfg_t    cfg;
    word_t   push_word;
    word_t   word_head;
    logic    word_valid;
    logic    word_pop;
    logic    fifo_full;
    logic    res_push;
    result_t res_data;
    result_t res_head;

    assign push_word = '{image_word: image_word, first_word: first_word};

    // front: register writes and incoming word requests
    mbb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .push_word  (push_word),
        .word_valid (word_valid),
        .word_head  (word_head),
        .word_pop   (word_pop),
        .cfg        (cfg)
    );

    // back: one bit per cycle unless stalled, clip, address, last marking
    mbb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .word_valid (word_valid),
        .word_head  (word_head),
        .word_pop   (word_pop),
        .fifo_full  (fifo_full),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    // result queue decouples the walker from the consumer
    mbb_result_fifo u_result_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (fifo_full),
        .empty   (empty),
        .pop     (pop),
        .head    (res_head)
    );

    assign pixel_address = res_head.pixel_address;
    assign color_rgb     = res_head.color_rgb;
    assign last          = res_head.last;

endmodule

/* hdl/mbb_front.sv */
// Front end: configuration registers and the word queue feeding the bit walker.
// Depends on mbb_pkg.
`timescale 1ns / 1ps

module mbb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [mbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          push,
    output logic                          full,
    input  mbb_pkg::word_t                push_word,
    output logic                          word_valid,
    output mbb_pkg::word_t                word_head,
    input  logic                          word_pop,
    output mbb_pkg::cfg_t                 cfg
);
    import mbb_pkg::*;

    localparam int PTR_W = $clog2(IQ_DEPTH);
    localparam int CNT_W = $clog2(IQ_DEPTH + 1);

    cfg_t             cfg_reg;
    word_t            q_reg [IQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_START_X:       cfg_reg.start_x       <= cfg_data[POS_W-1:0];
                REG_START_Y:       cfg_reg.start_y       <= cfg_data[POS_W-1:0];
                REG_BITMAP_WIDTH:  cfg_reg.bitmap_width  <= cfg_data[DIM_W-1:0];
                REG_BITMAP_HEIGHT: cfg_reg.bitmap_height <= cfg_data[DIM_W-1:0];
                REG_COLOR_INDEX:   cfg_reg.color_index   <= cfg_data[COLOR_W-1:0];
                default:           ;
            endcase
        end
    end

    assign full       = (count_reg == CNT_W'(IQ_DEPTH));
    assign do_push    = push && !full;
    assign word_valid = (count_reg != '0);
    assign word_head  = q_reg[rd_ptr_reg];
    assign cfg        = cfg_reg;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (word_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, word_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* hdl/mbb_back.sv */
// Back end: walks the bits of each word in turn, clips, forms addresses, marks last.
// Depends on mbb_pkg and the assertion header.
`timescale 1ns / 1ps
`include "mono_bitmap_blitter_top_assert.svh"

module mbb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mbb_pkg::cfg_t    cfg,
    input  logic             word_valid,
    input  mbb_pkg::word_t   word_head,
    output logic             word_pop,
    input  logic             fifo_full,
    output logic             res_push,
    output mbb_pkg::result_t res_data
);
    import mbb_pkg::*;

    // walker state
    logic                     busy_reg;
    logic [BITS_PER_WORD-1:0] word_reg;
    logic [BIT_IDX_W-1:0]     bit_cnt_reg;
    logic [DIM_W-1:0]         col_reg;
    logic [DIM_W-1:0]         row_reg;
    logic                     fin_reg;

    // address stage
    logic                     s2_hit_reg;
    logic                     s2_end_reg;
    logic [XW-1:0]            s2_x_reg;
    logic [YW-1:0]            s2_y_reg;

    // held write, released once the next one or the word end is known
    logic                     pend_valid_reg;
    logic                     pend_closed_reg;
    logic [ADDR_W-1:0]        pend_addr_reg;

    logic                     stall;
    logic                     step_end;
    logic                     hit;
    logic                     fin_next;
    logic [DIM_W-1:0]         col_next;
    logic [DIM_W-1:0]         row_next;
    logic [DIM_W-1:0]         c_cur;
    logic [DIM_W-1:0]         r_cur;
    logic [COORD_W-1:0]       x_sum;
    logic [COORD_W-1:0]       y_diff;
    logic [COORD_W-1:0]       x0;
    logic [COORD_W-1:0]       y0;
    logic                     on_screen;
    logic [PROD_W-1:0]        addr_full;

    assign stall = fifo_full;

    always_comb
    begin
        c_cur    = col_reg;
        r_cur    = row_reg;
        col_next = col_reg;
        row_next = row_reg;
        fin_next = fin_reg;
        step_end = 1'b0;
        hit      = 1'b0;
        x_sum  = {{(COORD_W-POS_W){cfg.start_x[POS_W-1]}}, cfg.start_x}
               + {{(COORD_W-DIM_W){1'b0}}, c_cur};
        y_diff = {{(COORD_W-POS_W){cfg.start_y[POS_W-1]}}, cfg.start_y}
               - {{(COORD_W-DIM_W){1'b0}}, r_cur};
        x0 = {x_sum[COORD_W-3:0], 2'b00};
        y0 = COORD_W'(Y_ORIGIN) - {y_diff[COORD_W-2:0], 1'b0};
        on_screen = 1'b0;
        if (busy_reg)
        begin
            if (fin_reg)
            begin
                step_end = 1'b1;
            end
            else if (cfg.bitmap_width == '0 || cfg.bitmap_height == '0
                     || row_reg >= cfg.bitmap_height)
            begin
                fin_next = 1'b1;
                step_end = 1'b1;
            end
            else
            begin
                // column left past a shrunk width: wrap before drawing
                if (col_reg >= cfg.bitmap_width)
                begin
                    c_cur = '0;
                    r_cur = row_reg + 1'b1;
                end
                col_next = c_cur;
                row_next = r_cur;
                if (r_cur >= cfg.bitmap_height)
                begin
                    fin_next = 1'b1;
                    step_end = 1'b1;
                end
                else
                begin
                    x_sum  = {{(COORD_W-POS_W){cfg.start_x[POS_W-1]}}, cfg.start_x}
                           + {{(COORD_W-DIM_W){1'b0}}, c_cur};
                    y_diff = {{(COORD_W-POS_W){cfg.start_y[POS_W-1]}}, cfg.start_y}
                           - {{(COORD_W-DIM_W){1'b0}}, r_cur};
                    x0 = {x_sum[COORD_W-3:0], 2'b00};
                    y0 = COORD_W'(Y_ORIGIN) - {y_diff[COORD_W-2:0], 1'b0};
                    on_screen = !x0[COORD_W-1] && !y0[COORD_W-1]
                             && (x0 < COORD_W'(FRAME_WIDTH))
                             && (y0 < COORD_W'(FRAME_HEIGHT));
                    hit = word_reg[BITS_PER_WORD-1] && on_screen;
                    col_next = c_cur + 1'b1;
                    if (col_next >= cfg.bitmap_width)
                    begin
                        col_next = '0;
                        row_next = r_cur + 1'b1;
                        if (row_next >= cfg.bitmap_height)
                        begin
                            fin_next = 1'b1;
                        end
                    end
                    // remaining bits are dead once the blit is over
                    step_end = (bit_cnt_reg == '0) || fin_next;
                end
            end
        end
    end

    assign word_pop = word_valid && !stall && (!busy_reg || step_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            fin_reg     <= 1'b1;
            col_reg     <= '0;
            row_reg     <= '0;
            bit_cnt_reg <= '0;
            s2_hit_reg  <= 1'b0;
            s2_end_reg  <= 1'b0;
        end
        else if (!stall)
        begin
            s2_hit_reg <= hit;
            s2_end_reg <= step_end;
            if (word_pop)
            begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= BIT_IDX_W'(BITS_PER_WORD - 1);
                if (word_head.first_word)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                    fin_reg <= 1'b0;
                end
                else
                begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                    fin_reg <= fin_next;
                end
            end
            else
            begin
                if (step_end)
                begin
                    busy_reg <= 1'b0;
                end
                if (busy_reg)
                begin
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                end
                col_reg <= col_next;
                row_reg <= row_next;
                fin_reg <= fin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            if (word_pop)
            begin
                word_reg <= word_head.image_word;
            end
            else
            begin
                word_reg <= {word_reg[BITS_PER_WORD-2:0], 1'b0};
            end
            s2_x_reg <= x0[XW-1:0];
            s2_y_reg <= y0[YW-1:0];
        end
    end

    assign addr_full = PROD_W'(s2_y_reg) * PROD_W'(FRAME_WIDTH) + PROD_W'(s2_x_reg);

    assign res_push = !stall && pend_valid_reg && (pend_closed_reg || s2_hit_reg);
    assign res_data = '{pixel_address: pend_addr_reg,
                        color_rgb:     ega_rgb(cfg.color_index),
                        last:          pend_closed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            pend_closed_reg <= 1'b0;
        end
        else if (!stall)
        begin
            if (s2_hit_reg)
            begin
                pend_valid_reg  <= 1'b1;
                pend_closed_reg <= s2_end_reg;
            end
            else if (s2_end_reg && pend_valid_reg && !pend_closed_reg)
            begin
                pend_closed_reg <= 1'b1;
            end
            else if (res_push)
            begin
                pend_valid_reg  <= 1'b0;
                pend_closed_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall && s2_hit_reg)
        begin
            pend_addr_reg <= addr_full[ADDR_W-1:0];
        end
    end

    `MBB_ASSERT_SAME(a_closed_has_data, pend_closed_reg, pend_valid_reg,
        "closed pending write without data")
    `MBB_ASSERT_NEXT(a_stall_keeps_pending, fifo_full && pend_valid_reg, pend_valid_reg,
        "pending write lost during stall")
    `MBB_ASSERT_NEXT(a_restart_opens_blit, word_pop && word_head.first_word,
        busy_reg && !fin_reg, "restart did not reopen the blit")
    `MBB_ASSERT_NEXT(a_end_frees_walker, step_end && !stall && !word_valid, !busy_reg,
        "walker stayed busy after word end")

endmodule

/* hdl/mbb_result_fifo.sv */
// Result queue between the back end and the result port.
// Depends on mbb_pkg.
`timescale 1ns / 1ps

module mbb_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  mbb_pkg::result_t wr_data,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output mbb_pkg::result_t head
);
    import mbb_pkg::*;

    localparam int PTR_W = $clog2(OQ_DEPTH);
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);

    result_t          q_reg [OQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full   = (count_reg == CNT_W'(OQ_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({wr_en, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
